[hw/rtl/pipas_pkg.sv]
package pipas_pkg;

  // Field and datapath widths
  localparam int COORD_W  = 32;  // Q16.16 coordinates
  localparam int ANG_W    = 32;  // angle in 2^-32 of a full turn
  localparam int TOTAL_W  = 40;  // running angle sum, saturating

  // Digit-serial CORDIC geometry
  localparam int ANG_ITER   = 32;
  localparam int CORDIC_W   = 36;  // holds |v| * gain with margin
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = CORDIC_W / DIGIT_W;

  localparam logic [ANG_W-1:0] HALF_TURN = 32'h8000_0000;

  // atan(2^-i) in 2^-32 turns
  localparam logic [ANG_W-1:0] ATAN_TBL [ANG_ITER] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // Inside window (358, 362) degrees as exact bounds on the sum:
  // sum > TOTAL_LO and sum <= TOTAL_HI (neither quotient is an integer).
  localparam longint unsigned DEG_PER_TURN = 360;
  localparam longint unsigned DEG_LO       = 358;
  localparam longint unsigned DEG_HI       = 362;
  localparam logic [TOTAL_W-1:0] TOTAL_LO  = TOTAL_W'((DEG_LO << ANG_W) / DEG_PER_TURN);
  localparam logic [TOTAL_W-1:0] TOTAL_HI  = TOTAL_W'((DEG_HI << ANG_W) / DEG_PER_TURN);

  // CORDIC result toward the control
  typedef struct packed {
    logic             done;  // one-cycle pulse
    logic             zero;  // vertex equals query point
    logic [ANG_W-1:0] dir;   // direction of vertex - point
  } pipas_dir_t;

  // Unsigned angle between two directions, in [0, half turn]
  function automatic logic [ANG_W-1:0] fold_ang(logic [ANG_W-1:0] from_dir,
                                                logic [ANG_W-1:0] to_dir);
    logic [ANG_W-1:0] d_fwd;
    logic [ANG_W-1:0] d_rev;
    d_fwd = to_dir - from_dir;
    d_rev = from_dir - to_dir;
    return (d_fwd > HALF_TURN) ? d_rev : d_fwd;
  endfunction

endpackage

[hw/rtl/point_in_polygon_angle_sum_core.sv]
// Point-in-polygon test by angle summation.
// Input channel (in_valid_i / in_stall_o): one polygon vertex per transaction.
//   first_vertex_i starts a polygon and latches point_x_i/point_y_i as the
//   query point; last_vertex_i adds the closing edge and produces a result.
// Output channel (out_valid_o / out_stall_i): one transaction per polygon,
//   inside_res_o and degenerate_o (vertex coincided with the query point).
// Each vertex runs one 32-iteration CORDIC, processed as 9 four-bit digits
//   per iteration, so the direction unit sets the pace: in_stall_o is high
//   from when a vertex is taken until control is back in its idle step.
//   A last vertex also adds the closing edge: its result is registered in
//   the final step, and the next vertex is accepted after that step.
// The output is a register of its own: a new vertex is accepted while a
//   result waits. If the receiver stalls and the next polygon finishes
//   first, the block holds that result in its final step until the
//   register frees up; no result is dropped or overwritten.
// Reset (async, active low) clears the query point, running sum and flags;
//   the stored previous/first vertices then read as the origin.
module point_in_polygon_angle_sum_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [pipas_pkg::COORD_W-1:0] vertex_x_i,
  input  logic signed [pipas_pkg::COORD_W-1:0] vertex_y_i,
  input  logic signed [pipas_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [pipas_pkg::COORD_W-1:0] point_y_i,
  input  logic                                 first_vertex_i,
  input  logic                                 last_vertex_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 inside_res_o,
  output logic                                 degenerate_o
);
  import pipas_pkg::*;

  // Control sequence per vertex
  localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for a vertex
  localparam logic [2:0] S_RUN   = 3'd1;  // CORDIC busy
  localparam logic [2:0] S_OPEN  = 3'd2;  // angle of edge prev -> current
  localparam logic [2:0] S_ADD1  = 3'd3;  // accumulate it
  localparam logic [2:0] S_CLOSE = 3'd4;  // angle of closing edge
  localparam logic [2:0] S_ADD2  = 3'd5;  // accumulate it
  localparam logic [2:0] S_RES   = 3'd6;  // window test, load output

  logic [2:0]                state_q;
  logic                      in_accept, out_free;
  pipas_dir_t                dir_res;

  // Latched transaction
  logic signed [COORD_W-1:0] vert_x_q, vert_y_q;
  logic signed [COORD_W-1:0] query_x_q, query_y_q;
  logic                      first_q, last_q;

  // Directions are cached instead of vertices: the query point only
  // changes on a first vertex, so each vertex needs one CORDIC pass.
  logic [ANG_W-1:0]          prev_dir_q, first_dir_q, cur_dir_q;
  logic                      prev_zero_q, first_zero_q, cur_zero_q;

  logic [ANG_W-1:0]          ang_q;
  logic [TOTAL_W-1:0]        total_q;
  logic                      poison_q;
  logic [TOTAL_W:0]          total_sum;
  logic [TOTAL_W-1:0]        total_sat;

  logic                      out_valid_q, inside_q, degen_q;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Saturating accumulate; folded angle never exceeds a half turn
  assign total_sum = {1'b0, total_q} + (TOTAL_W+1)'(ang_q);
  assign total_sat = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];

  pipas_cordic u_cordic (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_accept),
    .vert_x_i (vert_x_q),
    .vert_y_i (vert_y_q),
    .pt_x_i   (query_x_q),
    .pt_y_i   (query_y_q),
    .res_o    (dir_res)
  );

  // Vertex, current direction, working angle and result bits: payload only
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      vert_x_q <= vertex_x_i;
      vert_y_q <= vertex_y_i;
    end
    if (state_q == S_RUN && dir_res.done) begin
      cur_dir_q  <= dir_res.dir;
      cur_zero_q <= dir_res.zero;
    end
    if (state_q == S_OPEN) begin
      if (first_q || prev_zero_q || cur_zero_q) begin
        ang_q <= '0;
      end else begin
        ang_q <= fold_ang(prev_dir_q, cur_dir_q);
      end
    end else if (state_q == S_CLOSE) begin
      if (cur_zero_q || first_zero_q) begin
        ang_q <= '0;
      end else begin
        ang_q <= fold_ang(cur_dir_q, first_dir_q);
      end
    end
    if (state_q == S_RES && out_free) begin
      inside_q <= !poison_q && (total_q > TOTAL_LO) && (total_q <= TOTAL_HI);
      degen_q  <= poison_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      query_x_q    <= '0;
      query_y_q    <= '0;
      first_q      <= 1'b0;
      last_q       <= 1'b0;
      prev_dir_q   <= '0;
      first_dir_q  <= '0;
      prev_zero_q  <= 1'b1;  // origin vertex vs origin point
      first_zero_q <= 1'b1;
      total_q      <= '0;
      poison_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (state_q == S_RES && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            first_q <= first_vertex_i;
            last_q  <= last_vertex_i;
            if (first_vertex_i) begin
              query_x_q <= point_x_i;
              query_y_q <= point_y_i;
            end
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          if (dir_res.done) begin
            if (first_q) begin
              // new polygon: no edge yet
              total_q      <= '0;
              poison_q     <= 1'b0;
              first_dir_q  <= dir_res.dir;
              first_zero_q <= dir_res.zero;
            end
            state_q <= S_OPEN;
          end
        end
        S_OPEN: begin
          if (!first_q && (prev_zero_q || cur_zero_q)) begin
            poison_q <= 1'b1;
          end
          prev_dir_q  <= cur_dir_q;
          prev_zero_q <= cur_zero_q;
          state_q     <= S_ADD1;
        end
        S_ADD1: begin
          total_q <= total_sat;
          state_q <= last_q ? S_CLOSE : S_IDLE;
        end
        S_CLOSE: begin
          if (cur_zero_q || first_zero_q) begin
            poison_q <= 1'b1;
          end
          state_q <= S_ADD2;
        end
        S_ADD2: begin
          total_q <= total_sat;
          state_q <= S_RES;
        end
        S_RES: begin
          // hold here while an earlier result is still stalled
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;
  assign degenerate_o = degen_q;

`ifndef NO_ASSERTIONS
  // The direction unit only finishes while control waits for it
  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dir_res.done |-> (state_q == S_RUN))
    else $error("CORDIC finished outside the run step");

  // A degenerate polygon is never reported inside
  a_inside_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(inside_res_o && degenerate_o))
    else $error("inside and degenerate both set");

  // Folded edge angle stays within a half turn
  a_ang_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADD1 || state_q == S_ADD2) |-> (ang_q <= HALF_TURN))
    else $error("edge angle above half turn");

  // A new result only comes from the final step
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RES))
    else $error("result transaction without a closing step");
`endif

endmodule

[hw/rtl/pipas_cordic.sv]
module pipas_cordic (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [pipas_pkg::COORD_W-1:0] vert_x_i,
  input  logic signed [pipas_pkg::COORD_W-1:0] vert_y_i,
  input  logic signed [pipas_pkg::COORD_W-1:0] pt_x_i,
  input  logic signed [pipas_pkg::COORD_W-1:0] pt_y_i,
  output pipas_pkg::pipas_dir_t               res_o
);
  import pipas_pkg::*;

  localparam int DIG_CW  = $clog2(NUM_DIGITS);
  localparam int ITER_CW = $clog2(ANG_ITER);
  localparam int OFF_W   = $clog2(CORDIC_W);
  localparam int POS_W   = $clog2(CORDIC_W + ANG_ITER + DIGIT_W);
  localparam int TBL_IW  = $clog2(ANG_W);
  localparam int EXT_W   = CORDIC_W - COORD_W;

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_DIFF = 3'd1;
  localparam logic [2:0] C_PRE  = 3'd2;
  localparam logic [2:0] C_ITER = 3'd3;
  localparam logic [2:0] C_DONE = 3'd4;

  logic [2:0]          state_q;
  logic [CORDIC_W-1:0] x_q, y_q, z_q;  // rotate LSB digit first
  logic                x_sign_q, y_sign_q, y_nz_q, nz_acc_q;
  logic                cx_q, cy_q, cz_q, zero_q;
  logic [DIG_CW-1:0]   dig_q;
  logic [ITER_CW-1:0]  iter_q;

  logic                y_pos, first_dig, last_dig, y_nz_new;
  logic                x_cin, y_cin, z_cin, pre_neg;
  logic [DIGIT_W-1:0]  dx_dig, dy_dig, tz_dig, x_op, y_op, z_op;
  logic [DIGIT_W:0]    x_sum, y_sum, z_sum;
  logic [CORDIC_W-1:0] x_ext, y_ext, x_pre, y_pre;
  logic [OFF_W-1:0]    off;
  logic [POS_W-1:0]    pos, tpos;

  // Digit of (y >>> i), (x >>> i) and atan(2^-i) for this digit slot.
  // Bits past the top of the word read as the sign held from the
  // start of the iteration.
  always_comb begin
    dx_dig = '0;
    dy_dig = '0;
    tz_dig = '0;
    off    = '0;
    pos    = '0;
    tpos   = '0;
    for (int t = 0; t < DIGIT_W; t++) begin
      off  = OFF_W'(iter_q) + OFF_W'(t);
      pos  = POS_W'(dig_q) * POS_W'(DIGIT_W) + POS_W'(off);
      tpos = POS_W'(dig_q) * POS_W'(DIGIT_W) + POS_W'(t);
      dx_dig[t] = (pos < POS_W'(CORDIC_W)) ? y_q[off] : y_sign_q;
      dy_dig[t] = (pos < POS_W'(CORDIC_W)) ? x_q[off] : x_sign_q;
      tz_dig[t] = (tpos < POS_W'(ANG_W)) ? ATAN_TBL[iter_q][tpos[TBL_IW-1:0]] : 1'b0;
    end
  end

  always_comb begin
    y_pos     = !y_sign_q && y_nz_q;
    first_dig = (dig_q == '0);
    last_dig  = (dig_q == DIG_CW'(NUM_DIGITS - 1));

    x_op  = y_pos ? dx_dig : ~dx_dig;
    x_cin = first_dig ? !y_pos : cx_q;
    y_op  = y_pos ? ~dy_dig : dy_dig;
    y_cin = first_dig ? y_pos : cy_q;
    z_op  = y_pos ? tz_dig : ~tz_dig;
    z_cin = first_dig ? !y_pos : cz_q;

    x_sum = {1'b0, x_q[DIGIT_W-1:0]} + {1'b0, x_op} + (DIGIT_W+1)'(x_cin);
    y_sum = {1'b0, y_q[DIGIT_W-1:0]} + {1'b0, y_op} + (DIGIT_W+1)'(y_cin);
    z_sum = {1'b0, z_q[DIGIT_W-1:0]} + {1'b0, z_op} + (DIGIT_W+1)'(z_cin);

    y_nz_new = (first_dig ? 1'b0 : nz_acc_q) | (|y_sum[DIGIT_W-1:0]);

    x_ext = {{EXT_W{vert_x_i[COORD_W-1]}}, vert_x_i}
          - {{EXT_W{pt_x_i[COORD_W-1]}}, pt_x_i};
    y_ext = {{EXT_W{vert_y_i[COORD_W-1]}}, vert_y_i}
          - {{EXT_W{pt_y_i[COORD_W-1]}}, pt_y_i};

    // left half plane: rotate by a half turn first
    pre_neg = x_q[CORDIC_W-1];
    x_pre   = pre_neg ? ('0 - x_q) : x_q;
    y_pre   = pre_neg ? ('0 - y_q) : y_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= C_IDLE;
      x_q      <= '0;
      y_q      <= '0;
      z_q      <= '0;
      x_sign_q <= 1'b0;
      y_sign_q <= 1'b0;
      y_nz_q   <= 1'b0;
      nz_acc_q <= 1'b0;
      cx_q     <= 1'b0;
      cy_q     <= 1'b0;
      cz_q     <= 1'b0;
      zero_q   <= 1'b0;
      dig_q    <= '0;
      iter_q   <= '0;
    end else begin
      unique case (state_q)
        C_IDLE: begin
          if (start_i) begin
            state_q <= C_DIFF;
          end
        end
        C_DIFF: begin
          x_q     <= x_ext;
          y_q     <= y_ext;
          state_q <= C_PRE;
        end
        C_PRE: begin
          zero_q   <= (x_q == '0) && (y_q == '0);
          x_q      <= x_pre;
          y_q      <= y_pre;
          z_q      <= pre_neg ? CORDIC_W'(HALF_TURN) : '0;
          x_sign_q <= x_pre[CORDIC_W-1];
          y_sign_q <= y_pre[CORDIC_W-1];
          y_nz_q   <= |y_pre;
          dig_q    <= '0;
          iter_q   <= '0;
          state_q  <= C_ITER;
        end
        C_ITER: begin
          x_q      <= {x_sum[DIGIT_W-1:0], x_q[CORDIC_W-1:DIGIT_W]};
          y_q      <= {y_sum[DIGIT_W-1:0], y_q[CORDIC_W-1:DIGIT_W]};
          z_q      <= {z_sum[DIGIT_W-1:0], z_q[CORDIC_W-1:DIGIT_W]};
          cx_q     <= x_sum[DIGIT_W];
          cy_q     <= y_sum[DIGIT_W];
          cz_q     <= z_sum[DIGIT_W];
          nz_acc_q <= y_nz_new;
          if (last_dig) begin
            dig_q    <= '0;
            x_sign_q <= x_sum[DIGIT_W-1];
            y_sign_q <= y_sum[DIGIT_W-1];
            y_nz_q   <= y_nz_new;
            iter_q   <= iter_q + 1'b1;
            if (iter_q == ITER_CW'(ANG_ITER - 1)) begin
              state_q <= C_DONE;
            end
          end else begin
            dig_q <= dig_q + 1'b1;
          end
        end
        C_DONE: begin
          state_q <= C_IDLE;
        end
        default: begin
          state_q <= C_IDLE;
        end
      endcase
    end
  end

  assign res_o.done = (state_q == C_DONE);
  assign res_o.zero = zero_q;
  assign res_o.dir  = z_q[ANG_W-1:0];

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps

// One expected verdict per finished polygon.
typedef struct {
  bit in_poly;
  bit degenerate;
} verdict_t;

// Scoreboard: tracks the polygon state the block should hold and queues
// the verdict of every last-vertex transaction.
class angle_sum_checker;
  bit [31:0]       arctan [32];  // atan(2^-i), 2^-32 turn units
  longint          query_x, query_y, first_x, first_y, prev_x, prev_y;
  longint unsigned sweep;        // running angle sum, saturating at 40 bits
  longint unsigned sweep_cap;
  bit              poisoned;
  verdict_t        verdicts_due [$];
  int              errors, results, insides, degens, saturated;

  function new();
    arctan = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };
    sweep_cap = (64'd1 << 40) - 64'd1;
    query_x = 0; query_y = 0; first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
    sweep = 0;
    poisoned = 0;
    errors = 0; results = 0; insides = 0; degens = 0; saturated = 0;
  endfunction

  // CORDIC vectoring direction of (x, y)
  function bit [31:0] heading(longint x, longint y);
    bit [31:0] z;
    longint    dx, dy;
    int        i;
    z = 32'h0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (i = 0; i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx;
        y -= dy;
        z += arctan[i];
      end else begin
        x -= dx;
        y += dy;
        z -= arctan[i];
      end
    end
    return z;
  endfunction

  // Unsigned angle of edge a->b seen from the query point, added to the sweep
  function void sweep_edge(longint ax, longint ay, longint bx, longint by);
    longint    vax, vay, vbx, vby;
    bit [31:0] d;
    vax = ax - query_x; vay = ay - query_y;
    vbx = bx - query_x; vby = by - query_y;
    if ((vax == 0 && vay == 0) || (vbx == 0 && vby == 0)) begin
      poisoned = 1;
      return;
    end
    d = heading(vbx, vby) - heading(vax, vay);
    if (d > 32'h8000_0000) d = 32'h0 - d;
    if (sweep > sweep_cap - longint'(d)) sweep = sweep_cap;
    else sweep += longint'(d);
  endfunction

  function void note_vertex(longint vx, longint vy, longint px, longint py,
                            bit first, bit last);
    verdict_t v;
    if (first) begin
      query_x = px; query_y = py;
      first_x = vx; first_y = vy;
      sweep = 0;
      poisoned = 0;
    end else begin
      sweep_edge(prev_x, prev_y, vx, vy);
    end
    prev_x = vx;
    prev_y = vy;
    if (last) begin
      sweep_edge(vx, vy, first_x, first_y);
      v.degenerate = poisoned;
      v.in_poly = !poisoned && (sweep * 64'd360 > (64'd358 << 32)) &&
                  (sweep * 64'd360 < (64'd362 << 32));
      if (v.in_poly) insides++;
      if (v.degenerate) degens++;
      if (sweep == sweep_cap) saturated++;
      verdicts_due = {verdicts_due, v};
    end
  endfunction

  task report(string msg);
    $display("MISMATCH after %0d verdicts: %s", results, msg);
    errors++;
  endtask

  task check_result(logic in_poly, logic degenerate);
    verdict_t v;
    if (verdicts_due.size() == 0) begin
      report("verdict with no polygon pending");
      return;
    end
    v = verdicts_due.pop_front();
    results++;
    if (in_poly !== v.in_poly)
      report($sformatf("inside_res_o=%b, predicted %b", in_poly, v.in_poly));
    if (degenerate !== v.degenerate)
      report($sformatf("degenerate_o=%b, predicted %b", degenerate, v.degenerate));
  endtask
endclass

module tb;
  import pipas_pkg::*;

  // Generous bound on the run of ~1400 vertices, several times over
  localparam int CYCLE_LIMIT = 2_000_000;

  localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7fff_ffff;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                      in_valid_i;
  logic                      in_stall_o;
  logic signed [COORD_W-1:0] vertex_x_i, vertex_y_i, point_x_i, point_y_i;
  logic                      first_vertex_i, last_vertex_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic                      inside_res_o, degenerate_o;

  angle_sum_checker sb = new();

  int  cycles = 0;
  int  vertices_sent = 0;
  bit  calm = 0;   // final stretch: no gaps, no stalls
  bit  brisk = 0;  // current polygon sent back to back

  point_in_polygon_angle_sum_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .vertex_x_i     (vertex_x_i),
    .vertex_y_i     (vertex_y_i),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .first_vertex_i (first_vertex_i),
    .last_vertex_i  (last_vertex_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .inside_res_o   (inside_res_o),
    .degenerate_o   (degenerate_o)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Output monitor: values read here are the pre-edge ones
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(inside_res_o, degenerate_o);
  end

  // Receiver back-pressure: free runs, then stall bursts
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      if (!calm) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Full-range coordinate, biased toward the extremes and zero
  function automatic logic signed [COORD_W-1:0] any_coord();
    case ($urandom_range(0, 7))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Radius over many scales, up to 2^28 so center +/- 3r stays in range
  function automatic longint pick_radius();
    return longint'($urandom_range(1, 1 << $urandom_range(0, 28)));
  endfunction

  function automatic longint pick_center();
    return longint'($urandom_range(0, 1 << 30)) - (longint'(1) << 29);
  endfunction

  // One vertex transaction. Payload is set once and held while stalled;
  // valid stays high into the next call unless a gap is taken.
  task automatic send_vertex(input logic signed [COORD_W-1:0] vx, vy, px, py,
                             input bit first, input bit last);
    vertex_x_i     <= vx;
    vertex_y_i     <= vy;
    point_x_i      <= px;
    point_y_i      <= py;
    first_vertex_i <= first;
    last_vertex_i  <= last;
    in_valid_i     <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    sb.note_vertex(vx, vy, px, py, first, last);
    vertices_sent++;
    if (!calm && !brisk && $urandom_range(0, 9) < 3) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // Star-shaped polygon: n vertices walked around the boundary of a square
  // of half-side r at (cx,cy); query point at center + (ox,oy). Vertex
  // number hole (if in range) is replaced by the query point itself.
  task automatic send_square(input longint cx, cy, r, ox, oy,
                             input int n, input int hole);
    longint perim, step, s, side, f, sx, sy, px, py;
    bit     mirror;
    int     k;
    px = cx + ox;
    py = cy + oy;
    perim = 8 * r;
    step = perim / n;
    mirror = $urandom_range(0, 1);  // clockwise walk
    for (k = 0; k < n; k++) begin
      s = k * step;
      if (step > 1) s += longint'($urandom_range(0, step / 2));
      s = s % perim;
      side = s / (2 * r);
      f = s % (2 * r);
      case (side)
        0:       begin sx = r;      sy = -r + f; end
        1:       begin sx = r - f;  sy = r;      end
        2:       begin sx = -r;     sy = r - f;  end
        default: begin sx = -r + f; sy = -r;     end
      endcase
      if (mirror) sy = -sy;
      if (k == hole)
        send_vertex(COORD_W'(px), COORD_W'(py),
                    k == 0 ? COORD_W'(px) : any_coord(),
                    k == 0 ? COORD_W'(py) : any_coord(),
                    k == 0, k == n - 1);
      else
        send_vertex(COORD_W'(cx + sx), COORD_W'(cy + sy),
                    k == 0 ? COORD_W'(px) : any_coord(),
                    k == 0 ? COORD_W'(py) : any_coord(),
                    k == 0, k == n - 1);
    end
  endtask

  initial begin
    int     kind, n, k;
    longint cx, cy, r, ox, oy, jog;
    bit     drained, long_done;
    drained = 0;
    long_done = 0;

    in_valid_i     <= 1'b0;
    vertex_x_i     <= '0;
    vertex_y_i     <= '0;
    point_x_i      <= '0;
    point_y_i      <= '0;
    first_vertex_i <= 1'b0;
    last_vertex_i  <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part ----
    // No first vertex right after reset: origin point, origin previous vertex
    send_vertex(0, 0, C_MAX, C_MIN, 0, 1);
    // First and last on one transaction: closing edge to itself
    send_vertex(5, 7, 1, 1, 1, 1);
    send_vertex(-3, 9, -3, 9, 1, 1);
    // Extreme square around the origin
    send_vertex(C_MAX, C_MAX, 0, 0, 1, 0);
    send_vertex(C_MIN, C_MAX, C_MIN, C_MAX, 0, 0);
    send_vertex(C_MIN, C_MIN, C_MAX, C_MIN, 0, 0);
    send_vertex(C_MAX, C_MIN, C_MAX, C_MAX, 0, 1);
    // Same square with the point on a corner: 33-bit vectors, degenerate
    send_vertex(C_MAX, C_MAX, C_MIN, C_MIN, 1, 0);
    send_vertex(C_MIN, C_MAX, 0, 0, 0, 0);
    send_vertex(C_MIN, C_MIN, 0, 0, 0, 0);
    send_vertex(C_MAX, C_MIN, 0, 0, 0, 1);
    // Far corner point, outside
    send_vertex(C_MIN, 0, C_MAX, C_MAX, 1, 0);
    send_vertex(0, C_MIN, 0, 0, 0, 0);
    send_vertex(C_MIN, C_MIN, 0, 0, 0, 1);
    // Continuation after a finished polygon: no first vertex
    send_vertex(C_MAX, 0, 0, 0, 0, 0);
    send_vertex(0, C_MAX, 0, 0, 0, 1);
    // Smallest square around the origin
    send_square(0, 0, 1, 0, 0, 4, -1);

    // ---- random part ----
    while (vertices_sent < 1400) begin
      if (vertices_sent > 1250) calm = 1;
      brisk = ($urandom_range(0, 3) == 0);

      if (!drained && vertices_sent > 700) begin
        // Hold the sender until every verdict is out
        drained = 1;
        in_valid_i <= 1'b0;
        while (sb.verdicts_due.size() != 0) @(posedge clk_i);
        @(posedge clk_i);
      end

      kind = $urandom_range(0, 99);
      if (!long_done && vertices_sent > 400) begin
        // Near-antipodal zig-zag: ~180 degrees per edge drives the sum
        // into saturation before the last vertex
        long_done = 1;
        cx = pick_center();
        cy = pick_center();
        r = longint'(1) << $urandom_range(10, 28);
        for (k = 0; k < 540; k++) begin
          jog = longint'($urandom_range(0, r >> 6));
          if (k % 2 == 0)
            send_vertex(COORD_W'(cx + r), COORD_W'(cy + jog), COORD_W'(cx), COORD_W'(cy),
                        k == 0, 0);
          else
            send_vertex(COORD_W'(cx - r), COORD_W'(cy - jog), any_coord(), any_coord(),
                        0, k == 539);
        end
      end else if (kind < 50) begin
        // Well-formed, point inside
        r = pick_radius();
        ox = longint'($urandom_range(0, r)) - r / 2;
        oy = longint'($urandom_range(0, r)) - r / 2;
        send_square(pick_center(), pick_center(), r, ox, oy, $urandom_range(3, 10), -1);
      end else if (kind < 62) begin
        // Well-formed, point outside the square
        r = pick_radius();
        ox = r + longint'($urandom_range(1, 2 * r));
        if ($urandom_range(0, 1)) ox = -ox;
        oy = longint'($urandom_range(0, 6 * r)) - 3 * r;
        if ($urandom_range(0, 1))
          send_square(pick_center(), pick_center(), r, ox, oy, $urandom_range(3, 10), -1);
        else
          send_square(pick_center(), pick_center(), r, oy, ox, $urandom_range(3, 10), -1);
      end else if (kind < 72) begin
        // A vertex on the query point
        n = $urandom_range(3, 8);
        r = pick_radius();
        send_square(pick_center(), pick_center(), r, 0, 0, n, $urandom_range(0, n - 1));
      end else if (kind < 84) begin
        // Arbitrary full-range polygon
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++)
          send_vertex(any_coord(), any_coord(), any_coord(), any_coord(),
                      k == 0, k == n - 1);
      end else if (kind < 92) begin
        // Missing first vertex: carries on from the stored state
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++)
          send_vertex(any_coord(), any_coord(), any_coord(), any_coord(), 0, k == n - 1);
      end else begin
        // Polygon abandoned before its last vertex
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++)
          send_vertex(any_coord(), any_coord(), any_coord(), any_coord(), k == 0, 0);
      end
    end

    in_valid_i <= 1'b0;
    while (sb.verdicts_due.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);

    $display("covered %0d vertex transactions, %0d verdicts (%0d inside, %0d degenerate)",
             vertices_sent, sb.results, sb.insides, sb.degens);
    $display("sum saturated in %0d polygon(s); gaps and stalls on both channels", sb.saturated);
    if (sb.errors == 0 && sb.verdicts_due.size() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

[point_in_polygon_angle_sum_core.f]
hw/rtl/pipas_pkg.sv
hw/rtl/pipas_cordic.sv
hw/rtl/point_in_polygon_angle_sum_core.sv
bench/tb.sv
